// ===== rtl/lcr_pkg.sv =====
// Shared types and constants for the lattice coefficient rounding unit.
package lcr_pkg;

    typedef enum logic [1:0] {
        OP_POWER2ROUND,
        OP_DECOMPOSE,
        OP_MAKE_HINT,
        OP_USE_HINT
    } lcr_op_t;

    localparam int COEFFS_DEFAULT = 256;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [22:0] Q_MOD      = 23'd8380417;
    localparam int          D_BITS     = 13;
    localparam logic [23:0] P2R_ROUND  = 24'd4095;
    localparam logic [23:0] DEC_ROUND  = 24'd127;
    localparam logic [30:0] DEC_MULT   = 31'd11275;
    localparam logic [31:0] DEC_BIAS   = 32'd8388608;
    localparam logic [23:0] ALPHA      = 24'd190464;
    localparam logic signed [23:0] HALF_Q = 24'sd4190208;
    localparam logic [23:0] Q_WIDE     = 24'd8380417;
    localparam logic signed [22:0] GAMMA2     = 23'sd95232;
    localparam logic signed [22:0] NEG_GAMMA2 = -23'sd95232;
    localparam logic [7:0]  DEC_HIGH_LIMIT = 8'd43;
    localparam logic [5:0]  HIGH_MAX   = 6'd43;
    localparam logic [8:0]  COUNT_MAX  = 9'd511;

    // One classified item as it travels from the front part to the back part.
    typedef struct packed {
        lcr_op_t     op;
        logic [22:0] a;
        logic        hint;
        logic        flag;
        logic [7:0]  idx;
        logic [8:0]  total;
    } lcr_job_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_AW:0]   count;
    } lcr_q_status_t;

endpackage

// ===== rtl/lcr_if.sv =====
// Handshake channels for coefficient items and result items.
interface lcr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [22:0]        coeff;
    logic signed [22:0] low_in;
    logic [5:0]         high_in;
    logic               hint_in;
    logic               last;

    modport source (output valid, opcode, coeff, low_in, high_in, hint_in, last,
                    input ready);
    modport sink (input valid, opcode, coeff, low_in, high_in, hint_in, last,
                  output ready);
endinterface

interface lcr_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         high_out;
    logic signed [22:0] low_out;
    logic               hint_flag;
    logic [7:0]         hint_index;
    logic [8:0]         hint_total;

    modport source (output valid, high_out, low_out, hint_flag, hint_index, hint_total,
                    input ready);
    modport sink (input valid, high_out, low_out, hint_flag, hint_index, hint_total,
                  output ready);
endinterface

// ===== rtl/lcr_front.sv =====
// Front part: accepts items, reduces coefficients and runs the make-hint counters.
module lcr_front #(
    parameter int COEFFS = lcr_pkg::COEFFS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    lcr_in_if.sink           op_ch,
    output lcr_pkg::lcr_job_t job,
    output logic             push,
    input  logic             q_ready
);

    lcr_pkg::lcr_op_t op;
    logic [22:0]      a_red;
    logic             flag;
    logic [8:0]       cnt;
    logic             pos_wrap;
    logic             accept;
    logic [7:0]       position_reg;
    logic [7:0]       position_next;
    logic [8:0]       hint_count_reg;
    logic [8:0]       hint_count_next;

    assign op          = lcr_pkg::lcr_op_t'(op_ch.opcode);
    assign op_ch.ready = q_ready;
    assign accept      = op_ch.valid && q_ready;
    assign push        = accept;

    assign a_red = (op_ch.coeff >= lcr_pkg::Q_MOD) ? op_ch.coeff - lcr_pkg::Q_MOD
                                                   : op_ch.coeff;

    assign flag = (op_ch.low_in > lcr_pkg::GAMMA2) || (op_ch.low_in < lcr_pkg::NEG_GAMMA2)
                  || ((op_ch.low_in == lcr_pkg::NEG_GAMMA2) && (op_ch.high_in != 6'd0));

    assign cnt = (flag && (hint_count_reg != lcr_pkg::COUNT_MAX)) ? hint_count_reg + 9'd1
                                                                  : hint_count_reg;

    assign pos_wrap = ({1'b0, position_reg} + 9'd1) >= 9'(COEFFS);

    always_comb
    begin
        job.op    = op;
        job.a     = a_red;
        job.hint  = op_ch.hint_in;
        job.flag  = 1'b0;
        job.idx   = 8'd0;
        job.total = 9'd0;
        if (op == lcr_pkg::OP_MAKE_HINT)
        begin
            job.a     = 23'd0;
            job.flag  = flag;
            job.idx   = position_reg;
            job.total = cnt;
        end
    end

    always_comb
    begin
        position_next   = position_reg;
        hint_count_next = hint_count_reg;
        if (accept && (op == lcr_pkg::OP_MAKE_HINT))
        begin
            if (op_ch.last)
            begin
                position_next   = 8'd0;
                hint_count_next = 9'd0;
            end
            else
            begin
                position_next   = pos_wrap ? 8'd0 : position_reg + 8'd1;
                hint_count_next = cnt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= 8'd0;
            hint_count_reg <= 9'd0;
        end
        else
        begin
            position_reg   <= position_next;
            hint_count_reg <= hint_count_next;
        end
    end

endmodule

// ===== rtl/lcr_queue.sv =====
// Short queue of classified items between the front and back parts.
module lcr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcr_pkg::lcr_job_t      wr_job,
    input  logic                   push,
    output logic                   wr_ready,
    output lcr_pkg::lcr_job_t      rd_job,
    output logic                   rd_valid,
    input  logic                   pop_ready,
    output lcr_pkg::lcr_q_status_t status
);

    lcr_pkg::lcr_job_t              entry_reg [lcr_pkg::QUEUE_DEPTH];
    logic [lcr_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [lcr_pkg::QUEUE_AW-1:0]   wr_ptr_next;
    logic [lcr_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [lcr_pkg::QUEUE_AW-1:0]   rd_ptr_next;
    logic [lcr_pkg::QUEUE_AW:0]     count_reg;
    logic [lcr_pkg::QUEUE_AW:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    assign status.full  = (count_reg == (lcr_pkg::QUEUE_AW + 1)'(lcr_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

    assign wr_ready = !status.full;
    assign rd_valid = !status.empty;
    assign rd_job   = entry_reg[rd_ptr_reg];
    assign do_push  = push && !status.full;
    assign do_pop   = rd_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/lcr_back.sv =====
// Back part: three-stage rounding pipeline ending in the result register.
module lcr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lcr_pkg::lcr_job_t job,
    input  logic              job_valid,
    output logic              job_ready,
    lcr_out_if.source         res_ch
);

    logic                      adv1;
    logic                      adv2;
    logic                      adv3;

    logic [23:0]               sum_p2r;
    logic [9:0]                hi_p2r;
    logic [22:0]               lo_p2r;
    logic [23:0]               sum_dec;
    logic [16:0]               quot;
    logic [30:0]               prod;

    logic                      s1_valid_reg;
    lcr_pkg::lcr_job_t         s1_job_reg;
    logic [30:0]               s1_prod_reg;
    logic [9:0]                s1_hi_p2r_reg;
    logic [22:0]               s1_lo_p2r_reg;

    logic [31:0]               sum_bias;
    logic [7:0]                h_raw;
    logic [5:0]                h_dec;
    logic signed [23:0]        l_raw;

    logic                      s2_valid_reg;
    lcr_pkg::lcr_job_t         s2_job_reg;
    logic [9:0]                s2_hi_p2r_reg;
    logic [22:0]               s2_lo_p2r_reg;
    logic [5:0]                s2_h_reg;
    logic signed [23:0]        s2_lraw_reg;

    logic signed [23:0]        l_dec;
    logic [5:0]                h_use;
    logic [9:0]                high_next;
    logic [22:0]               low_next;

    logic                      res_valid_reg;
    logic [9:0]                res_high_reg;
    logic [22:0]               res_low_reg;
    logic                      res_flag_reg;
    logic [7:0]                res_idx_reg;
    logic [8:0]                res_total_reg;

    assign adv3      = !res_valid_reg || res_ch.ready;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign job_ready = adv1;

    assign sum_p2r = {1'b0, job.a} + lcr_pkg::P2R_ROUND;
    assign hi_p2r  = sum_p2r[22:lcr_pkg::D_BITS];
    assign lo_p2r  = 23'({1'b0, job.a} - {1'b0, hi_p2r, 13'd0});
    assign sum_dec = {1'b0, job.a} + lcr_pkg::DEC_ROUND;
    assign quot    = sum_dec[23:7];
    assign prod    = 31'(quot) * lcr_pkg::DEC_MULT;

    assign sum_bias = {1'b0, s1_prod_reg} + lcr_pkg::DEC_BIAS;
    assign h_raw    = sum_bias[31:24];
    assign h_dec    = (h_raw > lcr_pkg::DEC_HIGH_LIMIT) ? 6'd0 : h_raw[5:0];
    assign l_raw    = signed'({1'b0, s1_job_reg.a} - 24'(h_dec) * lcr_pkg::ALPHA);

    assign l_dec = (s2_lraw_reg > lcr_pkg::HALF_Q) ? s2_lraw_reg - signed'(lcr_pkg::Q_WIDE)
                                                  : s2_lraw_reg;

    always_comb
    begin
        h_use = s2_h_reg;
        if (s2_job_reg.hint)
        begin
            if (!l_dec[23])
            begin
                h_use = (s2_h_reg == lcr_pkg::HIGH_MAX) ? 6'd0 : s2_h_reg + 6'd1;
            end
            else
            begin
                h_use = (s2_h_reg == 6'd0) ? lcr_pkg::HIGH_MAX : s2_h_reg - 6'd1;
            end
        end
    end

    always_comb
    begin
        case (s2_job_reg.op)
            lcr_pkg::OP_POWER2ROUND:
            begin
                high_next = s2_hi_p2r_reg;
                low_next  = s2_lo_p2r_reg;
            end
            lcr_pkg::OP_DECOMPOSE:
            begin
                high_next = {4'd0, s2_h_reg};
                low_next  = l_dec[22:0];
            end
            lcr_pkg::OP_USE_HINT:
            begin
                high_next = {4'd0, h_use};
                low_next  = 23'd0;
            end
            default:
            begin
                high_next = 10'd0;
                low_next  = 23'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_job_reg    <= job;
            s1_prod_reg   <= prod;
            s1_hi_p2r_reg <= hi_p2r;
            s1_lo_p2r_reg <= lo_p2r;
        end
        if (adv2)
        begin
            s2_job_reg    <= s1_job_reg;
            s2_hi_p2r_reg <= s1_hi_p2r_reg;
            s2_lo_p2r_reg <= s1_lo_p2r_reg;
            s2_h_reg      <= h_dec;
            s2_lraw_reg   <= l_raw;
        end
        if (adv3)
        begin
            res_high_reg  <= high_next;
            res_low_reg   <= low_next;
            res_flag_reg  <= s2_job_reg.flag;
            res_idx_reg   <= s2_job_reg.idx;
            res_total_reg <= s2_job_reg.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= job_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                res_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign res_ch.valid      = res_valid_reg;
    assign res_ch.high_out   = res_high_reg;
    assign res_ch.low_out    = signed'(res_low_reg);
    assign res_ch.hint_flag  = res_flag_reg;
    assign res_ch.hint_index = res_idx_reg;
    assign res_ch.hint_total = res_total_reg;

endmodule

// ===== rtl/lattice_coeff_rounding_unit.sv =====
// Top level of the lattice coefficient rounding unit.
// Items enter on op_ch: an opcode selects power2round, decompose, make hint or
// use hint for one coefficient. One result item per input item leaves on res_ch,
// in input order, both channels using a valid/ready handshake.
// The front part reduces the coefficient and runs the make-hint position and
// hint counters; a four-entry queue decouples it from a three-stage back part.
// The back part is set by its decompose multiplier stage, its high-part stage and
// its correction stage, which also holds the result register.
// An accepted item is registered in the queue, then in the three back stages.
// Throughput: one item per cycle while res_ch is ready.
// When res_ch stalls, the pipeline holds and the queue fills; op_ch.ready drops
// only when the queue is full, so up to seven items are held during a stall.
// Reset clears the counters, the queue and all valid flags; no clearing pass
// is needed and the first item is accepted right after reset.
// After a make-hint item with last set, position and hint count restart at zero.
module lattice_coeff_rounding_unit #(
    parameter int COEFFS = lcr_pkg::COEFFS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    lcr_in_if.sink    op_ch,
    lcr_out_if.source res_ch
);

    lcr_pkg::lcr_job_t      front_job;
    logic                   front_push;
    logic                   q_wr_ready;
    lcr_pkg::lcr_job_t      q_job;
    logic                   q_valid;
    logic                   back_ready;
    lcr_pkg::lcr_q_status_t q_status;

    lcr_front #(
        .COEFFS (COEFFS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_ch   (op_ch),
        .job     (front_job),
        .push    (front_push),
        .q_ready (q_wr_ready)
    );

    lcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_job    (front_job),
        .push      (front_push),
        .wr_ready  (q_wr_ready),
        .rd_job    (q_job),
        .rd_valid  (q_valid),
        .pop_ready (back_ready),
        .status    (q_status)
    );

    lcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (q_job),
        .job_valid (q_valid),
        .job_ready (back_ready),
        .res_ch    (res_ch)
    );

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= (lcr_pkg::QUEUE_AW + 1)'(lcr_pkg::QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !op_ch.ready)
        else $error("Input is ready while the queue is full.");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.empty && !(op_ch.valid && op_ch.ready) |=> q_status.empty)
        else $error("Queue became non-empty without an accepted item.");

    a_flag_counted: assert property (@(posedge clk) disable iff (!rst_n)
        res_ch.valid && res_ch.hint_flag |-> res_ch.hint_total != 9'd0)
        else $error("A flagged hint result carries a zero hint total.");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the lattice coefficient rounding unit.
module tb_top;

    localparam int COEFFS      = 256;
    localparam int Q_VAL       = 8380417;
    localparam int ALPHA_VAL   = 190464;
    localparam int GAMMA2_VAL  = 95232;
    localparam int HALF_Q_VAL  = 4190208;
    localparam int HIGH_LIMIT  = 43;
    localparam int COUNT_LIMIT = 511;
    localparam int D_SHIFT     = 13;
    localparam int P2R_BIAS    = 4095;
    localparam int DEC_ROUNDING = 127;
    localparam int DEC_MUL     = 11275;
    localparam int DEC_OFFSET  = 8388608;

    typedef struct packed {
        lcr_pkg::lcr_op_t   op;
        logic [22:0]        coeff;
        logic signed [22:0] low;
        logic [5:0]         high;
        logic               hint;
        logic               last;
    } coeff_item_t;

    typedef struct packed {
        logic [9:0]         high;
        logic signed [22:0] low;
        logic               flag;
        logic [7:0]         index;
        logic [8:0]         total;
    } rounding_result_t;

    class rounding_scoreboard;
        rounding_result_t expected_results[$];
        logic [7:0]       position;
        logic [8:0]       hint_count;
        int               error_count;

        function new();
            position = '0;
            hint_count = '0;
            error_count = 0;
        endfunction

        function longint reduce_mod(logic [22:0] c);
            longint a;
            a = c;
            if (a >= Q_VAL)
                a -= Q_VAL;
            return a;
        endfunction

        function void split_alpha(input longint a, output longint hi, output longint lo);
            hi = (((a + DEC_ROUNDING) >>> 7) * DEC_MUL + DEC_OFFSET) >>> 24;
            if (hi > HIGH_LIMIT)
                hi = 0;
            lo = a - hi * ALPHA_VAL;
            if (lo > HALF_Q_VAL)
                lo -= Q_VAL;
        endfunction

        function rounding_result_t round_coeff(coeff_item_t it);
            rounding_result_t r;
            longint a;
            longint hi;
            longint lo;
            longint l;
            bit overflow;
            logic [8:0] cnt;
            int next_pos;
            r = '0;
            hi = 0;
            lo = 0;
            case (it.op)
                lcr_pkg::OP_POWER2ROUND:
                begin
                    a = reduce_mod(it.coeff);
                    hi = (a + P2R_BIAS) >>> D_SHIFT;
                    lo = a - (hi << D_SHIFT);
                end
                lcr_pkg::OP_DECOMPOSE:
                begin
                    split_alpha(reduce_mod(it.coeff), hi, lo);
                end
                lcr_pkg::OP_MAKE_HINT:
                begin
                    l = $signed(it.low);
                    overflow = (l > GAMMA2_VAL) || (l < -GAMMA2_VAL) ||
                               (l == -GAMMA2_VAL && it.high != 0);
                    cnt = hint_count;
                    if (overflow && cnt < COUNT_LIMIT)
                        cnt++;
                    r.flag = overflow;
                    r.index = position;
                    r.total = cnt;
                    if (it.last)
                    begin
                        position = '0;
                        hint_count = '0;
                    end
                    else
                    begin
                        next_pos = int'(position) + 1;
                        position = (next_pos >= COEFFS) ? 8'd0 : next_pos[7:0];
                        hint_count = cnt;
                    end
                end
                default:
                begin
                    split_alpha(reduce_mod(it.coeff), hi, l);
                    if (it.hint)
                    begin
                        hi += (l >= 0) ? 1 : -1;
                        if (hi < 0)
                            hi = HIGH_LIMIT;
                        else if (hi > HIGH_LIMIT)
                            hi = 0;
                    end
                    lo = 0;
                end
            endcase
            r.high = hi[9:0];
            r.low = lo[22:0];
            return r;
        endfunction

        function string describe(rounding_result_t r);
            return $sformatf("high %0d low %0d flag %0d index %0d total %0d",
                             r.high, r.low, r.flag, r.index, r.total);
        endfunction

        function void flag_error(string msg);
            error_count++;
            if (error_count <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void note_item(coeff_item_t it);
            expected_results.push_back(round_coeff(it));
        endfunction

        function void check_result(rounding_result_t got);
            rounding_result_t want;
            if (expected_results.size() == 0)
            begin
                flag_error({"result with nothing expected: ", describe(got)});
                return;
            end
            want = expected_results.pop_front();
            if (got.high !== want.high || got.low !== want.low || got.flag !== want.flag ||
                got.index !== want.index || got.total !== want.total)
                flag_error({"expected ", describe(want), ", got ", describe(got)});
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    lcr_in_if  op_ch ();
    lcr_out_if res_ch ();

    rounding_scoreboard rounding_check = new();

    lattice_coeff_rounding_unit #(
        .COEFFS(COEFFS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .op_ch (op_ch),
        .res_ch(res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic coeff_item_t make_item(lcr_pkg::lcr_op_t op, int coeff, int low,
                                              int high, bit hint, bit last);
        coeff_item_t it;
        it.op = op;
        it.coeff = coeff[22:0];
        it.low = low[22:0];
        it.high = high[5:0];
        it.hint = hint;
        it.last = last;
        return it;
    endfunction

    function automatic logic [22:0] random_coeff();
        int v;
        case ($urandom_range(0, 9))
            0: v = ALPHA_VAL * int'($urandom_range(0, 44)) + int'($urandom_range(0, 6)) - 3;
            1: v = ALPHA_VAL * int'($urandom_range(0, 44)) + GAMMA2_VAL +
                   int'($urandom_range(0, 4)) - 2;
            2: v = 8192 * int'($urandom_range(0, 1023)) + 4096 + int'($urandom_range(0, 4)) - 2;
            3: v = $urandom_range(8380410, 8388607);
            default: v = $urandom_range(0, Q_VAL - 1);
        endcase
        return v[22:0];
    endfunction

    function automatic logic [22:0] random_low();
        int v;
        case ($urandom_range(0, 4))
            0: v = GAMMA2_VAL + int'($urandom_range(0, 4)) - 2;
            1: v = $urandom;
            2, 3: v = int'($urandom_range(0, 2 * HALF_Q_VAL)) - HALF_Q_VAL;
            default: v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v[22:0];
    endfunction

    function automatic int random_high();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(0, 63);
            default: return $urandom_range(0, HIGH_LIMIT);
        endcase
    endfunction

    function automatic coeff_item_t random_item(lcr_pkg::lcr_op_t op, bit last);
        return make_item(op, random_coeff(), random_low(), random_high(),
                         1'($urandom_range(0, 1)), last);
    endfunction

    function automatic int random_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 25;
            default: return 50;
        endcase
    endfunction

    task automatic send_item(coeff_item_t it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        op_ch.valid   <= 1'b1;
        op_ch.opcode  <= it.op;
        op_ch.coeff   <= it.coeff;
        op_ch.low_in  <= it.low;
        op_ch.high_in <= it.high;
        op_ch.hint_in <= it.hint;
        op_ch.last    <= it.last;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        rounding_check.note_item(it);
    endtask

    initial
    begin : receiver
        int stall_left;
        rounding_result_t got;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.high = res_ch.high_out;
                got.low = res_ch.low_out;
                got.flag = res_ch.hint_flag;
                got.index = res_ch.hint_index;
                got.total = res_ch.hint_total;
                rounding_check.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    res_ch.ready <= 1'b1;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                stall_left = $urandom_range(1, 8);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int sent;
        int len;
        int pick;
        int v;
        lcr_pkg::lcr_op_t op;
        rst_n         <= 1'b0;
        op_ch.valid   <= 1'b0;
        op_ch.opcode  <= '0;
        op_ch.coeff   <= '0;
        op_ch.low_in  <= '0;
        op_ch.high_in <= '0;
        op_ch.hint_in <= 1'b0;
        op_ch.last    <= 1'b0;
        res_ch.ready  <= 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_item(lcr_pkg::OP_POWER2ROUND, 0, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_POWER2ROUND, 8380416, 0, 0, 1, 0));
        send_item(make_item(lcr_pkg::OP_POWER2ROUND, 4095, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_POWER2ROUND, 4096, 0, 0, 0, 1));
        send_item(make_item(lcr_pkg::OP_POWER2ROUND, 8388607, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_DECOMPOSE, 0, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_DECOMPOSE, 8380416, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_DECOMPOSE, 95232, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_DECOMPOSE, 95233, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_DECOMPOSE, 8380417, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, 95232, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, 95233, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, -95232, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, -95232, 5, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, -95232, 63, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, 'h400000, 43, 0, 0));
        send_item(make_item(lcr_pkg::OP_MAKE_HINT, 0, 'h3FFFFF, 0, 0, 1));
        send_item(make_item(lcr_pkg::OP_USE_HINT, 0, 0, 0, 1, 0));
        send_item(make_item(lcr_pkg::OP_USE_HINT, 8380416, 0, 0, 1, 0));
        send_item(make_item(lcr_pkg::OP_USE_HINT, 8190952, 0, 0, 1, 0));
        send_item(make_item(lcr_pkg::OP_USE_HINT, 5000000, 0, 0, 0, 0));
        send_item(make_item(lcr_pkg::OP_USE_HINT, 8388607, 0, 0, 1, 1));

        sent = 0;
        while (sent < 280)
        begin
            send_idle_pct = random_idle_pct();
            recv_idle_pct = random_idle_pct();
            if ($urandom_range(0, 1))
            begin
                len = $urandom_range(1, 30);
                pick = $urandom_range(0, 9);
                for (int i = 0; i < len; i++)
                    send_item(random_item(lcr_pkg::OP_MAKE_HINT, i == len - 1 && pick != 0));
                sent += len;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 2))
                        0: op = lcr_pkg::OP_POWER2ROUND;
                        1: op = lcr_pkg::OP_DECOMPOSE;
                        default: op = lcr_pkg::OP_USE_HINT;
                    endcase
                    send_item(random_item(op, 1'($urandom_range(0, 1))));
                end
                sent += len;
            end
        end

        // Hold the input side until the result queue has fully drained.
        op_ch.valid <= 1'b0;
        @(posedge clk);
        while (rounding_check.expected_results.size() != 0)
            @(posedge clk);

        // A long run of make-hint items with no end mark, so that the position
        // wraps and the hint count can saturate, then one item that clears both.
        for (int i = 0; i < 531; i++)
        begin
            if (i % 60 == 0)
            begin
                send_idle_pct = random_idle_pct();
                recv_idle_pct = random_idle_pct();
            end
            if ($urandom_range(0, 9) == 0)
                v = random_low();
            else
            begin
                v = $urandom_range(GAMMA2_VAL + 1, HALF_Q_VAL);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            send_item(make_item(lcr_pkg::OP_MAKE_HINT, random_coeff(), v, random_high(),
                                1'($urandom_range(0, 1)), i == 530));
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 40; i++)
            send_item(random_item(lcr_pkg::lcr_op_t'($urandom_range(0, 3)),
                                  1'($urandom_range(0, 1))));
        op_ch.valid <= 1'b0;

        while (rounding_check.expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (rounding_check.error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("tb_top: errors");
        $finish;
    end
endmodule
